/* hdl/dwfs_pkg.sv */
// ----------------------------------------------------------------------------
// dwfs_pkg
// Shared types, command codes and sequencer phase codes for the display
// window fill sequencer.
// ----------------------------------------------------------------------------
package dwfs_pkg;

   // controller RAM size in native orientation
   localparam int unsigned CTRL_COLUMNS = 240;
   localparam int unsigned CTRL_ROWS    = 320;

   // geometry widths
   localparam int unsigned PW_W   = 8;
   localparam int unsigned PH_W   = 9;
   localparam int unsigned ROT_W  = 2;
   localparam int unsigned COORD_W = 9;
   localparam int unsigned WIN_W  = 16;
   localparam int unsigned CNT_W  = 17;
   localparam int unsigned CSR_W  = 9;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] MAX_PIXELS = '1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION     = 2'd2;

   // request selector
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_FILL   = 2'd1;
   localparam logic [1:0] FUNC_ORIENT = 2'd2;

   // request status
   localparam logic [1:0] STAT_NONE     = 2'd0;
   localparam logic [1:0] STAT_ACCEPTED = 2'd1;
   localparam logic [1:0] STAT_OFFSCR   = 2'd2;
   localparam logic [1:0] STAT_BUSY     = 2'd3;

   // controller commands
   localparam logic [7:0] CMD_CASET  = 8'h2A;
   localparam logic [7:0] CMD_RASET  = 8'h2B;
   localparam logic [7:0] CMD_RAMWR  = 8'h2C;
   localparam logic [7:0] CMD_MADCTL = 8'h36;

   // sequencer phases
   localparam logic [3:0] PH_IDLE        = 4'd0;
   localparam logic [3:0] PH_CASET_CMD   = 4'd1;
   localparam logic [3:0] PH_CASET_DATA  = 4'd2;
   localparam logic [3:0] PH_RASET_CMD   = 4'd3;
   localparam logic [3:0] PH_RASET_DATA  = 4'd4;
   localparam logic [3:0] PH_RAMWR_CMD   = 4'd5;
   localparam logic [3:0] PH_PIXELS      = 4'd6;
   localparam logic [3:0] PH_MADCTL_CMD  = 4'd7;
   localparam logic [3:0] PH_MADCTL_DATA = 4'd8;

   typedef struct packed {
      logic [COORD_W-1:0] x_offset;
      logic [COORD_W-1:0] y_offset;
      logic [COORD_W-1:0] screen_width;
      logic [COORD_W-1:0] screen_height;
   } geom_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       data_not_command;
      logic       select_active;
      logic       end_of_transfer;
      logic [1:0] request_status;
      logic       busy_res;
   } result_type;

   // orientation byte per quarter turn
   function automatic logic [7:0] orient_byte(input logic [ROT_W-1:0] rot);
      logic [7:0] b;
      case (rot)
         2'd0:    b = 8'hC0;
         2'd1:    b = 8'hA0;
         2'd2:    b = 8'h00;
         default: b = 8'h60;
      endcase
      return b;
   endfunction

endpackage

/* hdl/dwfs_geom.sv */
// ----------------------------------------------------------------------------
// dwfs_geom
// Rotated screen size and controller RAM offsets from the panel registers.
// ----------------------------------------------------------------------------
module dwfs_geom #(
   parameter int unsigned CONTROLLER_COLUMNS = dwfs_pkg::CTRL_COLUMNS,
   parameter int unsigned CONTROLLER_ROWS    = dwfs_pkg::CTRL_ROWS
) (
   input  logic [dwfs_pkg::PW_W-1:0]  panel_width,
   input  logic [dwfs_pkg::PH_W-1:0]  panel_height,
   input  logic [dwfs_pkg::ROT_W-1:0] rotation,
   output dwfs_pkg::geom_type         geom
);
   import dwfs_pkg::*;

   logic [PW_W-1:0]    col_diff;
   logic [PH_W-1:0]    row_diff;
   logic [COORD_W-1:0] col_ofs_a;
   logic [COORD_W-1:0] col_ofs_b;
   logic [COORD_W-1:0] row_ofs_a;
   logic [COORD_W-1:0] row_ofs_b;
   logic [PW_W:0]      col_diff_up;

   always_comb begin
      // panel larger than controller saturates the offset at zero
      col_diff = (panel_width < PW_W'(CONTROLLER_COLUMNS)) ?
                 PW_W'(CONTROLLER_COLUMNS) - panel_width : '0;
      row_diff = (PH_W'(panel_height) < PH_W'(CONTROLLER_ROWS)) ?
                 PH_W'(CONTROLLER_ROWS) - panel_height : '0;
      col_diff_up = {1'b0, col_diff} + (PW_W+1)'(1);

      if (panel_width == PW_W'(240) && panel_height == PH_W'(240)) begin
         row_ofs_a = COORD_W'(row_diff);
         row_ofs_b = '0;
         col_ofs_a = COORD_W'(col_diff);
         col_ofs_b = COORD_W'(col_diff);
      end else if (panel_width == PW_W'(135) && panel_height == PH_W'(240)) begin
         // odd leftover: rounded up in one pair of rotations, down in the other
         row_ofs_a = COORD_W'(row_diff >> 1);
         row_ofs_b = COORD_W'(row_diff >> 1);
         col_ofs_a = COORD_W'(col_diff_up >> 1);
         col_ofs_b = COORD_W'(col_diff >> 1);
      end else begin
         row_ofs_a = COORD_W'(row_diff >> 1);
         row_ofs_b = COORD_W'(row_diff >> 1);
         col_ofs_a = COORD_W'(col_diff >> 1);
         col_ofs_b = COORD_W'(col_diff >> 1);
      end

      case (rotation)
         2'd0: begin
            geom.x_offset      = col_ofs_a;
            geom.y_offset      = row_ofs_a;
            geom.screen_width  = COORD_W'(panel_width);
            geom.screen_height = COORD_W'(panel_height);
         end
         2'd1: begin
            geom.x_offset      = row_ofs_a;
            geom.y_offset      = col_ofs_b;
            geom.screen_width  = COORD_W'(panel_height);
            geom.screen_height = COORD_W'(panel_width);
         end
         2'd2: begin
            geom.x_offset      = col_ofs_b;
            geom.y_offset      = row_ofs_b;
            geom.screen_width  = COORD_W'(panel_width);
            geom.screen_height = COORD_W'(panel_height);
         end
         default: begin
            geom.x_offset      = row_ofs_b;
            geom.y_offset      = col_ofs_a;
            geom.screen_width  = COORD_W'(panel_height);
            geom.screen_height = COORD_W'(panel_width);
         end
      endcase
   end

endmodule

/* hdl/dwfs_engine.sv */
// ----------------------------------------------------------------------------
// dwfs_engine
// Transfer state and one request or tick per step: fill setup with clipping
// and offsets, orientation command, and the byte sequencer.
// ----------------------------------------------------------------------------
module dwfs_engine #(
   parameter int unsigned CONTROLLER_COLUMNS = dwfs_pkg::CTRL_COLUMNS,
   parameter int unsigned CONTROLLER_ROWS    = dwfs_pkg::CTRL_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [1:0]                    func,
   input  logic [dwfs_pkg::COORD_W-1:0]  x_start,
   input  logic [dwfs_pkg::COORD_W-1:0]  y_start,
   input  logic [dwfs_pkg::COORD_W-1:0]  rect_width,
   input  logic [dwfs_pkg::COORD_W-1:0]  rect_height,
   input  logic [15:0]                   fill_color,
   input  logic [dwfs_pkg::PW_W-1:0]     panel_width,
   input  logic [dwfs_pkg::PH_W-1:0]     panel_height,
   input  logic [dwfs_pkg::ROT_W-1:0]    rotation,
   output dwfs_pkg::result_type          result
);
   import dwfs_pkg::*;

   logic [3:0]       phase_ff, phase_in;
   logic [1:0]       byte_index_ff, byte_index_in;
   logic [WIN_W-1:0] col_first_ff, col_first_in;
   logic [WIN_W-1:0] col_last_ff, col_last_in;
   logic [WIN_W-1:0] row_first_ff, row_first_in;
   logic [WIN_W-1:0] row_last_ff, row_last_in;
   logic [15:0]      color_ff, color_in;
   logic [CNT_W-1:0] pixels_left_ff, pixels_left_in;
   logic             low_next_ff, low_next_in;

   geom_type             geom;
   logic [COORD_W:0]     x_end;
   logic [COORD_W:0]     y_end;
   logic [COORD_W-1:0]   w_clip;
   logic [COORD_W-1:0]   h_clip;
   logic [WIN_W-1:0]     col_first_new;
   logic [WIN_W-1:0]     row_first_new;
   logic [2*COORD_W-1:0] pixel_count;
   logic [CNT_W-1:0]     pixels_dec;
   logic [WIN_W-1:0]     win_first;
   logic [WIN_W-1:0]     win_last;
   logic [7:0]           win_byte;

   dwfs_geom #(
      .CONTROLLER_COLUMNS (CONTROLLER_COLUMNS),
      .CONTROLLER_ROWS    (CONTROLLER_ROWS)
   ) u_geom (
      .panel_width  (panel_width),
      .panel_height (panel_height),
      .rotation     (rotation),
      .geom         (geom)
   );

   always_comb begin
      x_end  = {1'b0, x_start} + {1'b0, rect_width};
      y_end  = {1'b0, y_start} + {1'b0, rect_height};
      w_clip = (x_end >= {1'b0, geom.screen_width})  ? geom.screen_width - x_start  : rect_width;
      h_clip = (y_end >= {1'b0, geom.screen_height}) ? geom.screen_height - y_start : rect_height;
      col_first_new = WIN_W'({1'b0, x_start} + {1'b0, geom.x_offset});
      row_first_new = WIN_W'({1'b0, y_start} + {1'b0, geom.y_offset});
      pixel_count   = w_clip * h_clip;
      pixels_dec    = (pixels_left_ff != '0) ? pixels_left_ff - CNT_W'(1) : '0;

      win_first = (phase_ff == PH_RASET_DATA) ? row_first_ff : col_first_ff;
      win_last  = (phase_ff == PH_RASET_DATA) ? row_last_ff  : col_last_ff;
      case (byte_index_ff)
         2'd0:    win_byte = win_first[15:8];
         2'd1:    win_byte = win_first[7:0];
         2'd2:    win_byte = win_last[15:8];
         default: win_byte = win_last[7:0];
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      col_first_in   = col_first_ff;
      col_last_in    = col_last_ff;
      row_first_in   = row_first_ff;
      row_last_in    = row_last_ff;
      color_in       = color_ff;
      pixels_left_in = pixels_left_ff;
      low_next_in    = low_next_ff;

      result.byte_valid       = 1'b0;
      result.out_byte         = '0;
      result.data_not_command = 1'b0;
      result.end_of_transfer  = 1'b0;
      result.request_status   = STAT_NONE;

      if (func == FUNC_FILL || func == FUNC_ORIENT) begin
         if (phase_ff != PH_IDLE) begin
            result.request_status = STAT_BUSY;
         end else if (func == FUNC_ORIENT) begin
            color_in = {8'h00, orient_byte(rotation)};
            phase_in = PH_MADCTL_CMD;
            result.request_status = STAT_ACCEPTED;
         end else if (x_start >= geom.screen_width || y_start >= geom.screen_height) begin
            result.request_status = STAT_OFFSCR;
         end else begin
            // zero size wraps the window end below its start
            col_first_in   = col_first_new;
            col_last_in    = col_first_new + WIN_W'(w_clip) - WIN_W'(1);
            row_first_in   = row_first_new;
            row_last_in    = row_first_new + WIN_W'(h_clip) - WIN_W'(1);
            pixels_left_in = (pixel_count > (2*COORD_W)'(MAX_PIXELS)) ?
                             MAX_PIXELS : CNT_W'(pixel_count);
            color_in       = fill_color;
            low_next_in    = 1'b0;
            byte_index_in  = '0;
            phase_in       = PH_CASET_CMD;
            result.request_status = STAT_ACCEPTED;
         end
      end else if (func == FUNC_TICK && phase_ff != PH_IDLE) begin
         result.byte_valid       = 1'b1;
         result.data_not_command = 1'b1;
         unique case (phase_ff)
            PH_CASET_CMD: begin
               result.out_byte         = CMD_CASET;
               result.data_not_command = 1'b0;
               byte_index_in           = '0;
               phase_in                = PH_CASET_DATA;
            end
            PH_CASET_DATA: begin
               result.out_byte = win_byte;
               byte_index_in   = byte_index_ff + 2'd1;
               if (byte_index_ff == 2'd3) begin
                  phase_in = PH_RASET_CMD;
               end
            end
            PH_RASET_CMD: begin
               result.out_byte         = CMD_RASET;
               result.data_not_command = 1'b0;
               byte_index_in           = '0;
               phase_in                = PH_RASET_DATA;
            end
            PH_RASET_DATA: begin
               result.out_byte = win_byte;
               byte_index_in   = byte_index_ff + 2'd1;
               if (byte_index_ff == 2'd3) begin
                  phase_in = PH_RAMWR_CMD;
               end
            end
            PH_RAMWR_CMD: begin
               result.out_byte         = CMD_RAMWR;
               result.data_not_command = 1'b0;
               if (pixels_left_ff == '0) begin
                  result.end_of_transfer = 1'b1;
                  phase_in               = PH_IDLE;
               end else begin
                  phase_in = PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               if (!low_next_ff) begin
                  result.out_byte = color_ff[15:8];
                  low_next_in     = 1'b1;
               end else begin
                  result.out_byte = color_ff[7:0];
                  low_next_in     = 1'b0;
                  pixels_left_in  = pixels_dec;
                  if (pixels_dec == '0) begin
                     result.end_of_transfer = 1'b1;
                     phase_in               = PH_IDLE;
                  end
               end
            end
            PH_MADCTL_CMD: begin
               result.out_byte         = CMD_MADCTL;
               result.data_not_command = 1'b0;
               phase_in                = PH_MADCTL_DATA;
            end
            PH_MADCTL_DATA: begin
               result.out_byte        = color_ff[7:0];
               result.end_of_transfer = 1'b1;
               phase_in               = PH_IDLE;
            end
            default: begin
               result.byte_valid       = 1'b0;
               result.data_not_command = 1'b0;
               phase_in                = PH_IDLE;
            end
         endcase
      end

      result.busy_res      = (phase_in != PH_IDLE);
      result.select_active = result.byte_valid | result.busy_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         byte_index_ff  <= '0;
         col_first_ff   <= '0;
         col_last_ff    <= '0;
         row_first_ff   <= '0;
         row_last_ff    <= '0;
         color_ff       <= '0;
         pixels_left_ff <= '0;
         low_next_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         col_first_ff   <= col_first_in;
         col_last_ff    <= col_last_in;
         row_first_ff   <= row_first_in;
         row_last_ff    <= row_last_in;
         color_ff       <= color_in;
         pixels_left_ff <= pixels_left_in;
         low_next_ff    <= low_next_in;
      end
   end

`ifndef ASSERT_OFF
   // pixel phase is only entered with pixels still owed
   a_pixels_owed: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PIXELS |-> pixels_left_ff != '0)
      else $error("pixel phase with zero pixels left");

   // window byte counter only moves inside the window data phases
   a_index_scope: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff != '0 |-> (phase_ff == PH_CASET_DATA || phase_ff == PH_RASET_DATA))
      else $error("byte index set outside window data");

   // a pending low byte only exists mid-pixel
   a_low_scope: assert property (@(posedge clock) disable iff (reset)
      low_next_ff |-> phase_ff == PH_PIXELS)
      else $error("low byte pending outside pixel phase");

   // last byte of a transfer leaves the sequencer idle
   a_eot_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && result.end_of_transfer |=> phase_ff == PH_IDLE)
      else $error("sequencer busy after last byte");
`endif

endmodule

/* hdl/display_window_fill_sequencer.sv */
// ----------------------------------------------------------------------------
// display_window_fill_sequencer
// Fill and orientation requests in, controller byte stream out, one byte per
// tick with data/command flag and chip-select span.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_*     in         request word: selector in tuser, rectangle and colour
//  rsp_*     out        one result word per request word, last byte on tlast
//  csr_*     in         panel width, panel height, rotation writes
//
//  path: rsp valid follows req accept through the input reg, then the result reg
//  throughput: one word per cycle unless rsp_tready stalls; sequencer updates once per step
//  stalls: rsp_tready low holds the result reg, then the input reg, then req
//  reset: synchronous; sequencer idle, registers back to 240 x 320, rotation 0
// ----------------------------------------------------------------------------
module display_window_fill_sequencer #(
   parameter int unsigned CONTROLLER_COLUMNS = dwfs_pkg::CTRL_COLUMNS,
   parameter int unsigned CONTROLLER_ROWS    = dwfs_pkg::CTRL_ROWS
) (
   input  logic                            clock,
   input  logic                            reset,
   // x_start[8:0] y_start[17:9] rect_width[26:18] rect_height[35:27]
   // fill_color[51:36], zero[55:52]
   input  logic [55:0]                     req_tdata,
   input  logic [1:0]                      req_tuser,   // func[1:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // out_byte[7:0] select_active[8] request_status[10:9] busy_res[11] zero[15:12]
   output logic [15:0]                     rsp_tdata,
   output logic [1:0]                      rsp_tuser,   // byte_valid[0] data_not_command[1]
   output logic                            rsp_tlast,   // end_of_transfer
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [dwfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dwfs_pkg::CSR_W-1:0]      csr_wdata
);
   import dwfs_pkg::*;

   logic [PW_W-1:0]  panel_width_ff;
   logic [PH_W-1:0]  panel_height_ff;
   logic [ROT_W-1:0] rotation_ff;

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         func_ff;
   logic [COORD_W-1:0] x_ff, y_ff, w_ff, h_ff;
   logic [15:0]        color_ff;

   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type step_res;
   logic       step_en;
   logic       req_fire;

   assign step_en    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff  <= PW_W'(240);
         panel_height_ff <= PH_W'(320);
         rotation_ff     <= '0;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_PANEL_WIDTH:  panel_width_ff  <= csr_wdata[PW_W-1:0];
               REG_PANEL_HEIGHT: panel_height_ff <= csr_wdata[PH_W-1:0];
               REG_ROTATION:     rotation_ff     <= csr_wdata[ROT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_tuser;
         x_ff     <= req_tdata[8:0];
         y_ff     <= req_tdata[17:9];
         w_ff     <= req_tdata[26:18];
         h_ff     <= req_tdata[35:27];
         color_ff <= req_tdata[51:36];
      end
      if (step_en) begin
         out_res_ff <= step_res;
      end
   end

   dwfs_engine #(
      .CONTROLLER_COLUMNS (CONTROLLER_COLUMNS),
      .CONTROLLER_ROWS    (CONTROLLER_ROWS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .func         (func_ff),
      .x_start      (x_ff),
      .y_start      (y_ff),
      .rect_width   (w_ff),
      .rect_height  (h_ff),
      .fill_color   (color_ff),
      .panel_width  (panel_width_ff),
      .panel_height (panel_height_ff),
      .rotation     (rotation_ff),
      .result       (step_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, out_res_ff.busy_res, out_res_ff.request_status,
                        out_res_ff.select_active, out_res_ff.out_byte};
   assign rsp_tuser  = {out_res_ff.data_not_command, out_res_ff.byte_valid};
   assign rsp_tlast  = out_res_ff.end_of_transfer;

endmodule
